>>> sv/wma6_pkg.sv
package wma6_pkg;

	localparam int NCH            = 6;
	localparam int VOL_CH         = 4;
	localparam int XW             = 40;
	localparam int PRICE_W        = 32;
	localparam int DEV_W          = 32;
	localparam int WL_W           = 7;
	localparam int DEF_MAX_WINDOW = 64;
	localparam int PCT_W          = 14;
	localparam int PROD_W         = XW + PCT_W;

	localparam logic [PCT_W-1:0] PCT_SCALE  = 14'd10000;
	localparam logic [WL_W-1:0]  WIN_RESET  = 7'd5;
	localparam logic             REG_WINDOW = 1'b0;

	typedef logic [NCH-1:0][XW-1:0] bar_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic cap;
		logic ld1;
		logic ld2;
		logic step;
	} lane_ctrl_t;

endpackage

>>> sv/wma6_cell.sv
module wma6_cell (
	input  logic           clk,
	input  logic           shift,
	input  logic           rot,
	input  wma6_pkg::bar_t left,
	input  wma6_pkg::bar_t right,
	output wma6_pkg::bar_t d
);

	wma6_pkg::bar_t d_q;

	// take the newer neighbor's bar on a new request, the next one on a rotation
	always_ff @(posedge clk) begin
		if (shift) begin
			d_q <= left;
		end else if (rot) begin
			d_q <= right;
		end
	end

	assign d = d_q;

endmodule

>>> sv/wma6_lane.sv
module wma6_lane #(
	parameter int MAX_WINDOW = wma6_pkg::DEF_MAX_WINDOW
) (
	input  logic                              clk,
	input  wma6_pkg::lane_ctrl_t              ctrl,
	input  logic [wma6_pkg::XW-1:0]           x,
	input  logic [$clog2(MAX_WINDOW*(MAX_WINDOW+1)/2+1)-1:0] denom,
	output logic [wma6_pkg::XW-1:0]           avg,
	output logic [wma6_pkg::DEV_W-1:0]        dev
);

	localparam int XW  = wma6_pkg::XW;
	localparam int DNW = $clog2(MAX_WINDOW*(MAX_WINDOW+1)/2+1);
	localparam int PW  = XW + $clog2(MAX_WINDOW+1);
	localparam int SW  = XW + DNW;
	localparam int DW  = (SW > wma6_pkg::PROD_W) ? SW : wma6_pkg::PROD_W;

	logic [PW-1:0]   p_q;
	logic [SW-1:0]   s_q;
	logic [XW-1:0]   prev_q;
	logic [XW-1:0]   avg_q;
	logic            neg_q;
	logic            zero_q;
	logic [DW-1:0]   quo_q;
	logic [XW:0]     rem_q;
	logic [XW-1:0]   dvs_q;

	logic [PW-1:0]   p_n;
	logic [XW:0]     rem_sh;
	logic            ge;
	logic [XW-1:0]   avg_now;
	logic            neg_now;
	logic [XW-1:0]   mag;
	logic [wma6_pkg::PROD_W-1:0] prod;

	assign p_n     = p_q + PW'(x);
	assign rem_sh  = {rem_q[XW-1:0], quo_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign avg_now = quo_q[XW-1:0];
	assign neg_now = prev_q < avg_now;
	assign mag     = neg_now ? (avg_now - prev_q) : (prev_q - avg_now);
	assign prod    = wma6_pkg::PROD_W'(mag) * wma6_pkg::PROD_W'(wma6_pkg::PCT_SCALE);

	// running prefix sum P and sum of prefixes S give the linear weights
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			p_q <= '0;
			s_q <= '0;
		end else if (ctrl.acc) begin
			p_q <= p_n;
			s_q <= s_q + SW'(p_n);
		end
		if (ctrl.cap) begin
			prev_q <= x;
		end
		if (ctrl.ld1) begin
			quo_q <= DW'(s_q);
			rem_q <= '0;
			dvs_q <= XW'(denom);
		end else if (ctrl.ld2) begin
			avg_q  <= avg_now;
			neg_q  <= neg_now;
			zero_q <= avg_now == '0;
			quo_q  <= DW'(prod);
			rem_q  <= '0;
			dvs_q  <= avg_now;
		end else if (ctrl.step) begin
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	// sign and saturate the percent quotient, or give zero when the average is zero
	always_comb begin
		dev = quo_q[31:0];
		if (zero_q) begin
			dev = '0;
		end else if (neg_q) begin
			if ((|quo_q[DW-1:32]) || (quo_q[31:0] > 32'h8000_0000)) begin
				dev = 32'h8000_0000;
			end else begin
				dev = 32'h0 - quo_q[31:0];
			end
		end else if (|quo_q[DW-1:31]) begin
			dev = 32'h7FFF_FFFF;
		end
	end

	assign avg = avg_q;

endmodule

>>> sv/weighted_moving_average_six_channel.sv
// Six-channel linearly weighted moving average over price bars.
// Input channel: in_valid/in_ready carries one bar per request (open, high,
// low, close, volume, adjusted close). Output channel: out_valid/out_ready
// carries averages and percent deviations of the previous bar, one result
// per bar once window_length+1 bars have arrived.
// Configuration: APB-style port, one register (window_length at address 0).
// History lives in a row of MAX_WINDOW+1 cells that shift on every request.
// Work per result: the row rotates one full lap while each lane accumulates
// the weighted sum, then a 1-bit-per-cycle divider in each lane runs twice
// (average, then percent), with a setup step between the two divisions and
// an output step at the end. The divider loops and the rotation lap make up
// most of this work.
// A request during warm-up is taken, shifts the history and gives no result.
// in_ready is high whenever the block is idle, even while a result waits in
// the output register; a new result holds in the lanes until the receiver
// takes the previous one.
// Reset clears the window register to 5, the bar count and the control state;
// history contents stay undefined until written.
module weighted_moving_average_six_channel #(
	parameter int MAX_WINDOW = wma6_pkg::DEF_MAX_WINDOW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] open_price,
	input  logic [31:0] high_price,
	input  logic [31:0] low_price,
	input  logic [31:0] close_price,
	input  logic [39:0] trade_volume,
	input  logic [31:0] adjusted_close,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] avg_open,
	output logic [31:0] avg_high,
	output logic [31:0] avg_low,
	output logic [31:0] avg_close,
	output logic [39:0] avg_volume,
	output logic [31:0] avg_adjusted,
	output logic signed [31:0] dev_open,
	output logic signed [31:0] dev_high,
	output logic signed [31:0] dev_low,
	output logic signed [31:0] dev_close,
	output logic signed [31:0] dev_volume,
	output logic signed [31:0] dev_adjusted
);

	localparam int XW    = wma6_pkg::XW;
	localparam int NCH   = wma6_pkg::NCH;
	localparam int DEPTH = MAX_WINDOW + 1;
	localparam int DNW   = $clog2(MAX_WINDOW*(MAX_WINDOW+1)/2+1);
	localparam int SW    = XW + DNW;
	localparam int DW    = (SW > wma6_pkg::PROD_W) ? SW : wma6_pkg::PROD_W;
	localparam int WW    = $clog2(MAX_WINDOW+3);
	localparam int CW    = $clog2(((DEPTH > DW) ? DEPTH : DW) + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ROT  = 5'b00010,
		S_DIV1 = 5'b00100,
		S_DIV2 = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                      st_q;
	logic [CW-1:0]               cnt_q;
	logic [WW-1:0]               bars_q;
	logic [wma6_pkg::WL_W-1:0]   wl_q;
	logic                        out_valid_q;

	logic [10:0]                 wl_ext;
	logic [WW-1:0]               w;
	logic [WW-1:0]               w1;
	logic [WW-1:0]               bars_n;
	logic [2*DNW+1:0]            dprod;
	logic [DNW-1:0]              denom;
	logic                        acc_in;
	logic                        out_take;
	logic                        out_load;
	logic                        cfg_wr;
	wma6_pkg::lane_ctrl_t        ctrl;
	wma6_pkg::bar_t              in_bar;
	wma6_pkg::bar_t              cell_d [DEPTH];
	logic [NCH-1:0][XW-1:0]      lane_avg;
	logic [NCH-1:0][31:0]        lane_dev;
	logic [NCH-1:0][XW-1:0]      avg_q;
	logic [NCH-1:0][31:0]        dev_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == wma6_pkg::REG_WINDOW);
	assign prdata = (paddr[2] == wma6_pkg::REG_WINDOW) ? 32'(wl_q) : 32'h0;

	// clamp the window into 1..MAX_WINDOW
	always_comb begin
		wl_ext = 11'(wl_q);
		if (wl_ext == 11'd0) begin
			w = WW'(1);
		end else if (wl_ext > 11'(MAX_WINDOW)) begin
			w = WW'(MAX_WINDOW);
		end else begin
			w = WW'(wl_ext);
		end
	end

	assign w1     = w + WW'(1);
	assign bars_n = ((bars_q + WW'(1)) > w1) ? w1 : (bars_q + WW'(1));
	assign dprod  = (2*DNW+2)'(w) * (2*DNW+2)'(w1);
	assign denom  = DNW'(dprod >> 1);

	assign acc_in   = in_valid & in_ready;
	assign in_ready = st_q == S_IDLE;
	assign out_take = out_valid_q & out_ready;
	// move the finished result into the output register once it is free
	assign out_load = (st_q == S_OUT) && (!out_valid_q || out_ready);

	assign in_bar[0] = XW'(open_price);
	assign in_bar[1] = XW'(high_price);
	assign in_bar[2] = XW'(low_price);
	assign in_bar[3] = XW'(close_price);
	assign in_bar[4] = trade_volume;
	assign in_bar[5] = XW'(adjusted_close);

	// history row: cell 0 holds the newest bar
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % DEPTH;
		wma6_cell u_cell (
			.clk   (clk),
			.shift (acc_in),
			.rot   (st_q == S_ROT),
			.left  ((i == 0) ? in_bar : cell_d[(i == 0) ? 0 : i-1]),
			.right (cell_d[NXT]),
			.d     (cell_d[i])
		);
	end

	// lane controls
	always_comb begin
		ctrl      = '0;
		ctrl.clr  = acc_in;
		ctrl.acc  = (st_q == S_ROT) && (cnt_q < CW'(w));
		ctrl.cap  = (st_q == S_ROT) && (cnt_q == CW'(1));
		ctrl.ld1  = (st_q == S_ROT) && (cnt_q == CW'(DEPTH-1));
		ctrl.ld2  = (st_q == S_DIV1) && (cnt_q == CW'(DW));
		ctrl.step = ((st_q == S_DIV1) || (st_q == S_DIV2)) && (cnt_q < CW'(DW));
	end

	for (genvar c = 0; c < NCH; c++) begin : g_lane
		wma6_lane #(.MAX_WINDOW(MAX_WINDOW)) u_lane (
			.clk   (clk),
			.ctrl  (ctrl),
			.x     (cell_d[0][c]),
			.denom (denom),
			.avg   (lane_avg[c]),
			.dev   (lane_dev[c])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
			bars_q      <= '0;
			wl_q        <= wma6_pkg::WIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				wl_q <= pwdata[wma6_pkg::WL_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (acc_in) begin
						bars_q <= bars_n;
						if (bars_n == w1) begin
							st_q <= S_ROT;
						end
					end
				end
				S_ROT: begin
					// rotate one full lap so the row ends where it started
					if (cnt_q == CW'(DEPTH-1)) begin
						cnt_q <= '0;
						st_q  <= S_DIV1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DIV1: begin
					// a final step after the quotient bits loads the percent division
					if (cnt_q == CW'(DW)) begin
						cnt_q <= '0;
						st_q  <= S_DIV2;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DIV2: begin
					if (cnt_q == CW'(DW-1)) begin
						st_q <= S_OUT;
					end
					cnt_q <= cnt_q + CW'(1);
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q <= lane_avg;
			dev_q <= lane_dev;
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_open     = avg_q[0][31:0];
	assign avg_high     = avg_q[1][31:0];
	assign avg_low      = avg_q[2][31:0];
	assign avg_close    = avg_q[3][31:0];
	assign avg_volume   = avg_q[4];
	assign avg_adjusted = avg_q[5][31:0];
	assign dev_open     = dev_q[0];
	assign dev_high     = dev_q[1];
	assign dev_low      = dev_q[2];
	assign dev_close    = dev_q[3];
	assign dev_volume   = dev_q[4];
	assign dev_adjusted = dev_q[5];

	a_bars_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bars_q <= WW'(DEPTH))
		else $error("bar count beyond history depth");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && (bars_n == w1)) |=> (st_q == S_ROT))
		else $error("full window did not start a computation");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && out_valid_q && !out_ready) |=> (st_q == S_OUT))
		else $error("result dropped while receiver stalled");

endmodule
